// ----- design/ptt_pkg.sv -----
// Package for the page table translation block: widths, codes and the
// payload and control structs shared by all of its modules.
// Depends on nothing.
package ptt_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned FNUM_W      = 8;
  localparam int unsigned PHYS_W      = 25;
  localparam int unsigned CFG_IDX_W   = 2;

  // Table depth follows the width of the page index field.
  localparam int unsigned PAGE_ENTRIES = 16;
  localparam int unsigned FRAME_BITS_DEFAULT = 8;

  // Configuration register reset values.
  localparam logic [ADDR_W-1:0]  PAGE_SIZE_RST  = 16'd1024;
  localparam logic [COUNT_W-1:0] PAGE_COUNT_RST = 5'd16;
  localparam logic [ADDR_W-1:0]  BASE_RST       = 16'd0;

  typedef enum logic {
    OP_MAP       = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_MAPPED       = 2'd0,
    ST_TRANSLATED   = 2'd1,
    ST_NOT_PRESENT  = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_SIZE  = 2'd0,
    CFG_PAGE_COUNT = 2'd1,
    CFG_BASE       = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  // Input beat.
  typedef struct packed {
    op_e                operation;
    logic [IDX_W-1:0]   page_index;
    logic [FNUM_W-1:0]  frame_number;
    logic [ADDR_W-1:0]  logical_address;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [PHYS_W-1:0]  physical_address;
    status_e            status;
  } out_t;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [ADDR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ADDR_W-1:0]  quotient;
    logic [ADDR_W-1:0]  remainder;
  } div_rsp_t;

  // Page table write control.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   idx;
  } tbl_wr_t;

endpackage

// ----- design/ptt_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ptt_pkg.
module ptt_divider
  import ptt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(ADDR_W + 1);

  logic [ADDR_W-1:0] dvd_q;
  logic [ADDR_W-1:0] rem_q;
  logic [ADDR_W-1:0] dsr_q;
  logic [CntW-1:0]   cnt_q;
  logic              done_q;
  logic [ADDR_W:0]   trial;
  logic [ADDR_W:0]   diff;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, dvd_q[ADDR_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = ~diff[ADDR_W];

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CntW'(1));
      if (req_i.start) begin
        cnt_q <= CntW'(ADDR_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Dividend shift register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
      dvd_q <= {dvd_q[ADDR_W-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- design/ptt_table.sv -----
// Page table storage: a frame number and a present bit per page.
// Depends on ptt_pkg.
module ptt_table
  import ptt_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbl_wr_t               wr_i,
  input  logic [FRAME_BITS-1:0] wr_frame_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  output logic                  rd_present_o,
  output logic [FRAME_BITS-1:0] rd_frame_o
);

  logic [PAGE_ENTRIES-1:0] present_q;
  logic [FRAME_BITS-1:0]   frame_q [PAGE_ENTRIES];
  logic [FRAME_BITS-1:0]   rd_frame_q;

  // Present bits clear at reset and set on every map write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (wr_i.we) begin
      present_q[wr_i.idx] <= 1'b1;
    end
  end

  // Frame numbers hold whatever was last written; the read is registered,
  // so the frame shows in the cycle after its index.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      frame_q[wr_i.idx] <= wr_frame_i;
    end
    rd_frame_q <= frame_q[rd_idx_i];
  end

  assign rd_present_o = present_q[rd_idx_i];
  assign rd_frame_o   = rd_frame_q;

endmodule

// ----- design/page_table_translate_top.sv -----
// Page table translation top level: configuration registers, sequencer,
// frame multiply and final add. Depends on ptt_pkg, ptt_divider, ptt_table.
// A map beat gives its result in the next cycle and busy stays low.
// A translate beat runs the bit-serial divider and then the page lookup:
// a fault ends busy there, a hit goes on to frame read, multiply and add.
// The result shows in the first cycle after busy falls, when the next
// beat may already be taken. A zero page size answers in the next cycle.
// Reset is asynchronous, active low; it clears all present bits and loads
// the configuration defaults. The result strobe cannot be stalled.
module page_table_translate_top
  import ptt_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_i,
  output logic                 done_o,
  output out_t                 result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  localparam int unsigned ProdW = FRAME_BITS + ADDR_W;
  localparam int unsigned SumW  = ProdW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_MUL  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [ADDR_W-1:0]     page_size_q;
  logic [COUNT_W-1:0]    page_count_q;
  logic [ADDR_W-1:0]     base_q;
  logic                  done_q, done_d;
  out_t                  result_q, result_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic [ADDR_W-1:0]     offset_q, offset_d;
  logic                  accept;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  tbl_wr_t               tbl_wr;
  logic                  rd_present;
  logic [FRAME_BITS-1:0] rd_frame;
  logic                  out_of_range;
  logic [SumW-1:0]       sum;

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q  <= PAGE_SIZE_RST;
      page_count_q <= PAGE_COUNT_RST;
      base_q       <= BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAGE_SIZE:  page_size_q  <= cfg_data_i;
        CFG_PAGE_COUNT: page_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_BASE:       base_q       <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Map beats write the table at acceptance.
  assign tbl_wr.we  = accept & (in_i.operation == OP_MAP);
  assign tbl_wr.idx = in_i.page_index;

  ptt_table #(
    .FRAME_BITS (FRAME_BITS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (tbl_wr),
    .wr_frame_i   (FRAME_BITS'(in_i.frame_number)),
    .rd_idx_i     (div_rsp.quotient[IDX_W-1:0]),
    .rd_present_o (rd_present),
    .rd_frame_o   (rd_frame)
  );

  // Translate beats with a nonzero page size start the divider.
  assign div_req.start    = accept & (in_i.operation == OP_TRANSLATE) & (page_size_q != '0);
  assign div_req.dividend = in_i.logical_address;
  assign div_req.divisor  = page_size_q;

  ptt_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Page check against the programmed count and the table depth.
  assign out_of_range = (div_rsp.quotient >= ADDR_W'(page_count_q)) ||
                        (div_rsp.quotient >= ADDR_W'(PAGE_ENTRIES));

  assign sum = SumW'(prod_q) + SumW'(base_q) + SumW'(offset_q);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    result_d = result_q;
    prod_d   = prod_q;
    offset_d = offset_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.operation == OP_MAP) begin
            done_d   = 1'b1;
            result_d = '{physical_address: '0, status: ST_MAPPED};
          end else if (page_size_q == '0) begin
            done_d   = 1'b1;
            result_d = '{physical_address: '0, status: ST_OUT_OF_RANGE};
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (out_of_range) begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            result_d = '{physical_address: '0, status: ST_OUT_OF_RANGE};
          end else if (!rd_present) begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            result_d = '{physical_address: '0, status: ST_NOT_PRESENT};
          end else begin
            state_d  = S_MUL;
            offset_d = div_rsp.remainder;
          end
        end
      end
      S_MUL: begin
        // The registered frame read is valid in this cycle.
        state_d = S_ADD;
        prod_d  = ProdW'(rd_frame) * ProdW'(page_size_q);
      end
      S_ADD: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        result_d = '{physical_address: PHYS_W'(sum), status: ST_TRANSLATED};
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    prod_q   <= prod_d;
    offset_q <= offset_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- design/ptt_checker.sv -----
// Port-level checker for the page table translation top level, with its bind.
// Depends on ptt_pkg and page_table_translate_top.
module ptt_checker
  import ptt_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  in_i,
  input logic done_o,
  input out_t result_o
);

  // A map beat is answered in the next cycle with a zero address.
  a_map_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.operation == OP_MAP) |=>
      (done_o && result_o.status == ST_MAPPED && result_o.physical_address == '0))
    else $error("map beat did not give a mapped result next cycle");

  // A translate beat either answers at once or keeps the block busy.
  a_translate_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.operation == OP_TRANSLATE) |=> (busy || done_o))
    else $error("translate beat was dropped");

  // The end of a busy period always delivers a result beat.
  a_busy_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy ended without a result beat");

  // Faults and map results carry a zero address, and no result shows while busy.
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && (result_o.status == ST_TRANSLATED ||
                          result_o.physical_address == '0)))
    else $error("result beat with nonzero address on a fault or while busy");

endmodule

bind page_table_translate_top ptt_checker u_ptt_checker (.*);
